/* src/segment_triangle_intersect_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the segment / triangle intersection block
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef SEGMENT_TRIANGLE_INTERSECT_DEFINES_SVH
`define SEGMENT_TRIANGLE_INTERSECT_DEFINES_SVH

// Same-cycle implication.
`define STI_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define STI_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/sti_pkg.sv */
// ----------------------------------------------------------------------------
// sti_pkg
// Shared constants, types and width helpers of the intersection block.
// ----------------------------------------------------------------------------
`default_nettype none

package sti_pkg;

  localparam int COORD_BITS_DEF = 20;
  localparam int FRAC_BITS_DEF  = 16;
  localparam int CFG_IDX_BITS   = 3;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_VERTEX_A       = 3'd0,
    REG_VERTEX_B       = 3'd1,
    REG_VERTEX_C       = 3'd2,
    REG_UNIT_NORMAL    = 3'd3,
    REG_INFLATE_RADIUS = 3'd4,
    REG_USE_TRANSLATED = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic hit;
    logic behind;
    logic singular;
  } item_flags_t;

  // Width of a difference vector component (shifted vertex plus one bit).
  function automatic int diff_w(input int c, input int f);
    int vw;
    vw = ((2 * c - f > c) ? 2 * c - f : c) + 1;
    return vw + 1;
  endfunction

  // Width of a 3x3 determinant of difference vectors.
  function automatic int det_w(input int c, input int f);
    return 3 * diff_w(c, f) + 2;
  endfunction

endpackage

`default_nettype wire

/* src/sti_geom.sv */
// ----------------------------------------------------------------------------
// sti_geom
// Difference vectors, cross products and the four exact determinants.
// ----------------------------------------------------------------------------
`default_nettype none

module sti_geom import sti_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   en,
  input  logic                                   in_valid,
  input  logic [6*COORD_BITS-1:0]                in_side,
  input  logic signed [COORD_BITS-1:0]           va [3],
  input  logic signed [COORD_BITS-1:0]           vb [3],
  input  logic signed [COORD_BITS-1:0]           vc [3],
  input  logic signed [COORD_BITS-1:0]           nrm [3],
  input  logic [COORD_BITS-2:0]                  radius,
  input  logic                                   use_tr,
  output logic                                   out_valid,
  output logic [6*COORD_BITS-1:0]                out_side,
  output logic                                   out_behind,
  output logic signed [det_w(COORD_BITS, FRAC_BITS)-1:0] dd,
  output logic signed [det_w(COORD_BITS, FRAC_BITS)-1:0] nt,
  output logic signed [det_w(COORD_BITS, FRAC_BITS)-1:0] nu,
  output logic signed [det_w(COORD_BITS, FRAC_BITS)-1:0] nv
);

  localparam int C    = COORD_BITS;
  localparam int F    = FRAC_BITS;
  localparam int SW   = 6 * C;
  localparam int DW   = diff_w(C, F);
  localparam int VW   = DW - 1;
  localparam int PW   = 2 * C;
  localparam int MW   = 2 * DW;
  localparam int CW   = 2 * DW + 1;
  localparam int LW   = (CW + 1) / 2;
  localparam int HW   = CW - LW;
  localparam int DPW  = C + DW;
  localparam int SUMW = C + DW + 2;
  localparam int PLW  = DW + LW + 1;
  localparam int PHW  = DW + HW;
  localparam int TW   = det_w(C, F);
  localparam logic signed [PW-1:0] HALF_F = PW'(1) <<< (F - 1);

  // Stage 1: radius times normal.
  logic                   s1_valid;
  logic [SW-1:0]          s1_side;
  logic signed [PW-1:0]   s1_rn [3];
  logic signed [C-1:0]    rad_s;

  assign rad_s = signed'({1'b0, radius});

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_side <= in_side;
      for (int j = 0; j < 3; j++) begin
        s1_rn[j] <= PW'(rad_s) * PW'(nrm[j]);
      end
    end
  end

  // Stage 2: offsets and difference vectors. The edge vectors do not see
  // the offset, which cancels between vertices.
  logic signed [PW-1:0] rnd [3];
  logic signed [VW-1:0] offv [3];
  logic signed [DW-1:0] a0_n [3];
  logic signed [DW-1:0] a1_n [3];
  logic signed [DW-1:0] a2_n [3];
  logic signed [DW-1:0] bv_n [3];

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      rnd[j]  = s1_rn[j] + HALF_F;
      offv[j] = use_tr ? VW'(rnd[j] >>> F) : '0;
      a0_n[j] = DW'(signed'(s1_side[j*C +: C])) - DW'(signed'(s1_side[(j+3)*C +: C]));
      a1_n[j] = DW'(vb[j]) - DW'(va[j]);
      a2_n[j] = DW'(vc[j]) - DW'(va[j]);
      bv_n[j] = DW'(signed'(s1_side[j*C +: C])) - DW'(va[j]) - DW'(offv[j]);
    end
  end

  logic                 s2_valid;
  logic [SW-1:0]        s2_side;
  logic signed [DW-1:0] s2_a0 [3];
  logic signed [DW-1:0] s2_a1 [3];
  logic signed [DW-1:0] s2_a2 [3];
  logic signed [DW-1:0] s2_bv [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (en) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_side <= s1_side;
      s2_a0   <= a0_n;
      s2_a1   <= a1_n;
      s2_a2   <= a2_n;
      s2_bv   <= bv_n;
    end
  end

  // Stage 3: cross product terms and normal dot products. Cross k takes
  // (a1,a2), (bv,a2) and (a1,bv).
  logic signed [DW-1:0] cq [3][3];
  logic signed [DW-1:0] cr [3][3];

  always_comb begin
    cq[0] = s2_a1; cr[0] = s2_a2;
    cq[1] = s2_bv; cr[1] = s2_a2;
    cq[2] = s2_a1; cr[2] = s2_bv;
  end

  logic                  s3_valid;
  logic [SW-1:0]         s3_side;
  logic signed [DW-1:0]  s3_a0 [3];
  logic signed [DW-1:0]  s3_bv [3];
  logic signed [MW-1:0]  s3_m1 [3][3];
  logic signed [MW-1:0]  s3_m2 [3][3];
  logic signed [DPW-1:0] s3_dp [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (en) begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_side <= s2_side;
      s3_a0   <= s2_a0;
      s3_bv   <= s2_bv;
      for (int k = 0; k < 3; k++) begin
        for (int j = 0; j < 3; j++) begin
          s3_m1[k][j] <= MW'(cq[k][(j+1)%3]) * MW'(cr[k][(j+2)%3]);
          s3_m2[k][j] <= MW'(cq[k][(j+2)%3]) * MW'(cr[k][(j+1)%3]);
        end
      end
      for (int j = 0; j < 3; j++) begin
        s3_dp[j] <= DPW'(nrm[j]) * DPW'(s2_bv[j]);
      end
    end
  end

  // Stage 4: cross components and the sign of the plane distance.
  logic signed [SUMW-1:0] dot_sum;

  assign dot_sum = SUMW'(s3_dp[0]) + SUMW'(s3_dp[1]) + SUMW'(s3_dp[2]);

  logic                 s4_valid;
  logic [SW-1:0]        s4_side;
  logic                 s4_behind;
  logic signed [DW-1:0] s4_a0 [3];
  logic signed [DW-1:0] s4_bv [3];
  logic signed [CW-1:0] s4_x [3][3];

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
    end else if (en) begin
      s4_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_side   <= s3_side;
      s4_behind <= dot_sum[SUMW-1];
      s4_a0     <= s3_a0;
      s4_bv     <= s3_bv;
      for (int k = 0; k < 3; k++) begin
        for (int j = 0; j < 3; j++) begin
          s4_x[k][j] <= CW'(s3_m1[k][j]) - CW'(s3_m2[k][j]);
        end
      end
    end
  end

  // Stage 5: partial products of the triple products. Determinant d is
  // dd, nt, nu, nv in that order; the cross term is split in two halves.
  logic signed [PLW-1:0] s5_pl [4][3];
  logic signed [PHW-1:0] s5_ph [4][3];
  logic                  s5_valid;
  logic [SW-1:0]         s5_side;
  logic                  s5_behind;

  always_ff @(posedge clk) begin
    if (rst) begin
      s5_valid <= 1'b0;
    end else if (en) begin
      s5_valid <= s4_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s5_side   <= s4_side;
      s5_behind <= s4_behind;
      for (int d = 0; d < 4; d++) begin
        for (int j = 0; j < 3; j++) begin
          s5_pl[d][j] <= PLW'((d == 1) ? s4_bv[j] : s4_a0[j])
                       * PLW'(signed'({1'b0, s4_x[(d < 2) ? 0 : d-1][j][LW-1:0]}));
          s5_ph[d][j] <= PHW'((d == 1) ? s4_bv[j] : s4_a0[j])
                       * PHW'(signed'(s4_x[(d < 2) ? 0 : d-1][j][CW-1:LW]));
        end
      end
    end
  end

  // Stage 6: whole terms.
  logic signed [TW-1:0] s6_t [4][3];
  logic                 s6_valid;
  logic [SW-1:0]        s6_side;
  logic                 s6_behind;

  always_ff @(posedge clk) begin
    if (rst) begin
      s6_valid <= 1'b0;
    end else if (en) begin
      s6_valid <= s5_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s6_side   <= s5_side;
      s6_behind <= s5_behind;
      for (int d = 0; d < 4; d++) begin
        for (int j = 0; j < 3; j++) begin
          s6_t[d][j] <= (TW'(s5_ph[d][j]) <<< LW) + TW'(s5_pl[d][j]);
        end
      end
    end
  end

  // Stage 7: determinants.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= s6_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_side   <= s6_side;
      out_behind <= s6_behind;
      dd <= s6_t[0][0] + s6_t[0][1] + s6_t[0][2];
      nt <= s6_t[1][0] + s6_t[1][1] + s6_t[1][2];
      nu <= s6_t[2][0] + s6_t[2][1] + s6_t[2][2];
      nv <= s6_t[3][0] + s6_t[3][1] + s6_t[3][2];
    end
  end

endmodule

`default_nettype wire

/* src/sti_div.sv */
// ----------------------------------------------------------------------------
// sti_div
// Sign normalisation, hit decision and a pipelined restoring divider for t.
// ----------------------------------------------------------------------------
`default_nettype none

module sti_div import sti_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   en,
  input  logic                                   in_valid,
  input  logic [6*COORD_BITS-1:0]                in_side,
  input  logic                                   in_behind,
  input  logic signed [det_w(COORD_BITS, FRAC_BITS)-1:0] dd,
  input  logic signed [det_w(COORD_BITS, FRAC_BITS)-1:0] nt,
  input  logic signed [det_w(COORD_BITS, FRAC_BITS)-1:0] nu,
  input  logic signed [det_w(COORD_BITS, FRAC_BITS)-1:0] nv,
  output logic                                   out_valid,
  output logic [6*COORD_BITS-1:0]                out_side,
  output item_flags_t                            out_flags,
  output logic signed [COORD_BITS-1:0]           tq
);

  localparam int C  = COORD_BITS;
  localparam int F  = FRAC_BITS;
  localparam int SW = 6 * C;
  localparam int TW = det_w(C, F);
  localparam int XW = TW + F + 2;
  localparam int RW = TW + F + C + 3;
  localparam logic [C-1:0]        LIM   = C'(1) << (C - 1);
  localparam logic signed [C-1:0] T_MAX = signed'(LIM - C'(1));
  localparam logic signed [C-1:0] T_MIN = signed'(LIM);

  // N1: make the determinant positive.
  logic                 n1_valid;
  logic [SW-1:0]        n1_side;
  item_flags_t          n1_flags;
  logic signed [TW-1:0] n1_dd, n1_nt, n1_nu, n1_nv;

  always_ff @(posedge clk) begin
    if (rst) begin
      n1_valid <= 1'b0;
    end else if (en) begin
      n1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n1_side           <= in_side;
      n1_flags.hit      <= 1'b0;
      n1_flags.behind   <= in_behind;
      n1_flags.singular <= (dd == '0);
      n1_dd <= dd[TW-1] ? -dd : dd;
      n1_nt <= dd[TW-1] ? -nt : nt;
      n1_nu <= dd[TW-1] ? -nu : nu;
      n1_nv <= dd[TW-1] ? -nv : nv;
    end
  end

  // N2: hit rule on exact numerators, dividend and divisor of the rounding.
  logic signed [TW:0] uv_sum;
  logic               t_in, t_nonpos, hit_n;

  always_comb begin
    uv_sum   = (TW+1)'(n1_nu) + (TW+1)'(n1_nv);
    t_in     = !n1_nt[TW-1] && (n1_nt <= n1_dd);
    t_nonpos = n1_nt[TW-1] || (n1_nt == '0);
    hit_n    = !n1_flags.singular && !n1_nu[TW-1] && !n1_nv[TW-1]
             && (uv_sum <= (TW+1)'(n1_dd)) && (t_in || (t_nonpos && n1_flags.behind));
  end

  logic                 n2_valid;
  logic [SW-1:0]        n2_side;
  item_flags_t          n2_flags;
  logic signed [XW-1:0] n2_x;
  logic [TW:0]          n2_d;

  always_ff @(posedge clk) begin
    if (rst) begin
      n2_valid <= 1'b0;
    end else if (en) begin
      n2_valid <= n1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n2_side           <= n1_side;
      n2_flags.hit      <= hit_n;
      n2_flags.behind   <= n1_flags.behind;
      n2_flags.singular <= n1_flags.singular;
      n2_x <= (XW'(n1_nt) <<< (F + 1)) + XW'(n1_dd);
      n2_d <= {n1_dd, 1'b0};
    end
  end

  // N3: magnitude for a floor division of a possibly negative dividend.
  logic signed [RW-1:0] xs, ds, mval;

  always_comb begin
    xs   = RW'(n2_x);
    ds   = signed'(RW'(n2_d));
    mval = n2_x[XW-1] ? (ds - xs - RW'(1)) : xs;
  end

  logic          n3_valid;
  logic [SW-1:0] n3_side;
  item_flags_t   n3_flags;
  logic [RW-1:0] n3_rem;
  logic [TW:0]   n3_d;
  logic          n3_neg;

  always_ff @(posedge clk) begin
    if (rst) begin
      n3_valid <= 1'b0;
    end else if (en) begin
      n3_valid <= n2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n3_side  <= n2_side;
      n3_flags <= n2_flags;
      n3_rem   <= mval;
      n3_d     <= n2_d;
      n3_neg   <= n2_x[XW-1];
    end
  end

  // Quotient pipeline: entry 0 holds the overflow check, entry i+1 the
  // result of quotient bit C-1-i.
  logic          st_valid [C+1];
  logic [SW-1:0] st_side  [C+1];
  item_flags_t   st_flags [C+1];
  logic [RW-1:0] st_rem   [C+1];
  logic [TW:0]   st_d     [C+1];
  logic [C-1:0]  st_q     [C+1];
  logic          st_neg   [C+1];
  logic          st_ovf   [C+1];
  logic [RW:0]   trial    [C];

  always_comb begin
    for (int i = 0; i < C; i++) begin
      trial[i] = {1'b0, st_rem[i]} - {1'b0, RW'(st_d[i]) << (C - 1 - i)};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i <= C; i++) begin
        st_valid[i] <= 1'b0;
      end
    end else if (en) begin
      st_valid[0] <= n3_valid;
      for (int i = 0; i < C; i++) begin
        st_valid[i+1] <= st_valid[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st_side[0]  <= n3_side;
      st_flags[0] <= n3_flags;
      st_rem[0]   <= n3_rem;
      st_d[0]     <= n3_d;
      st_q[0]     <= '0;
      st_neg[0]   <= n3_neg;
      st_ovf[0]   <= n3_rem >= (RW'(n3_d) << C);
      for (int i = 0; i < C; i++) begin
        st_side[i+1]  <= st_side[i];
        st_flags[i+1] <= st_flags[i];
        st_d[i+1]     <= st_d[i];
        st_neg[i+1]   <= st_neg[i];
        st_ovf[i+1]   <= st_ovf[i];
        st_rem[i+1]   <= trial[i][RW] ? st_rem[i] : trial[i][RW-1:0];
        st_q[i+1]     <= st_q[i] | (trial[i][RW] ? '0 : (C'(1) << (C - 1 - i)));
      end
    end
  end

  // Final stage: sign, saturation and the singular case.
  logic signed [C-1:0] t_res;
  logic                q_ge, q_gt;

  always_comb begin
    q_ge = st_ovf[C] || (st_q[C] >= LIM);
    q_gt = st_ovf[C] || (st_q[C] > LIM);
    if (st_flags[C].singular) begin
      t_res = '0;
    end else if (st_neg[C]) begin
      t_res = q_gt ? T_MIN : -signed'(st_q[C]);
    end else begin
      t_res = q_ge ? T_MAX : signed'(st_q[C]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= st_valid[C];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_side  <= st_side[C];
      out_flags <= st_flags[C];
      tq        <= t_res;
    end
  end

endmodule

`default_nettype wire

/* src/sti_out.sv */
// ----------------------------------------------------------------------------
// sti_out
// Intersection point from the reported t, output register and skid stage.
// ----------------------------------------------------------------------------
`default_nettype none

`include "segment_triangle_intersect_defines.svh"

module sti_out import sti_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  output logic                         en,
  input  logic                         in_valid,
  input  logic [6*COORD_BITS-1:0]      in_side,
  input  item_flags_t                  in_flags,
  input  logic signed [COORD_BITS-1:0] in_tq,
  output logic                         out_valid,
  input  logic                         out_ready,
  output item_flags_t                  out_flags,
  output logic [COORD_BITS-1:0]        out_tq,
  output logic [COORD_BITS-1:0]        out_px,
  output logic [COORD_BITS-1:0]        out_py,
  output logic [COORD_BITS-1:0]        out_pz
);

  localparam int C   = COORD_BITS;
  localparam int F   = FRAC_BITS;
  localparam int PRW = 2 * C + 1;
  localparam int SMW = PRW + 1;
  localparam logic signed [PRW-1:0] HALF_F = PRW'(1) <<< (F - 1);
  localparam logic signed [SMW-1:0] P_MAX  = SMW'((C'(1) << (C - 1)) - C'(1));
  localparam logic signed [SMW-1:0] P_MIN  = -P_MAX - SMW'(1);

  // The result record as it sits in the output register and the skid stage.
  typedef struct packed {
    item_flags_t  flags;
    logic [C-1:0] tq;
    logic [C-1:0] px;
    logic [C-1:0] py;
    logic [C-1:0] pz;
  } result_t;

  logic    skid_valid;
  result_t skid, outr, res;

  assign en = !skid_valid;

  // P1: t times the motion delta.
  logic                  p1_valid;
  item_flags_t           p1_flags;
  logic signed [C-1:0]   p1_tq;
  logic signed [C-1:0]   p1_cur  [3];
  logic signed [PRW-1:0] p1_prod [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
    end else if (en) begin
      p1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_flags <= in_flags;
      p1_tq    <= in_tq;
      for (int j = 0; j < 3; j++) begin
        p1_cur[j]  <= signed'(in_side[j*C +: C]);
        p1_prod[j] <= PRW'(in_tq) * PRW'((C+1)'(signed'(in_side[(j+3)*C +: C]))
                                       - (C+1)'(signed'(in_side[j*C +: C])));
      end
    end
  end

  // Rounding, addition and saturation of each axis.
  logic signed [PRW-1:0] offs [3];
  logic signed [SMW-1:0] psum [3];
  logic [C-1:0]          pnt  [3];

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      offs[j] = (p1_prod[j] + HALF_F) >>> F;
      psum[j] = SMW'(p1_cur[j]) + SMW'(offs[j]);
      if (psum[j] > P_MAX) begin
        pnt[j] = P_MAX[C-1:0];
      end else if (psum[j] < P_MIN) begin
        pnt[j] = P_MIN[C-1:0];
      end else begin
        pnt[j] = psum[j][C-1:0];
      end
    end
    res.flags = p1_flags;
    res.tq    = p1_tq;
    res.px    = pnt[0];
    res.py    = pnt[1];
    res.pz    = pnt[2];
  end

  // Output register with a one-entry skid stage behind it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      out_valid  <= skid_valid || p1_valid;
      skid_valid <= 1'b0;
    end else if (en && p1_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || out_ready) begin
      outr <= skid_valid ? skid : res;
    end else if (en && p1_valid) begin
      skid <= res;
    end
  end

  assign out_flags = outr.flags;
  assign out_tq    = outr.tq;
  assign out_px    = outr.px;
  assign out_py    = outr.py;
  assign out_pz    = outr.pz;

  `STI_ASSERT_NOW(a_skid_behind_out, skid_valid, out_valid, "skid holds a result without an output")
  `STI_ASSERT_NOW(a_skid_fill, $rose(skid_valid), $past(out_valid && !out_ready), "skid filled without a stall")
  `STI_ASSERT_NOW(a_singular_clean, out_valid && outr.flags.singular, !outr.flags.hit && (outr.tq == '0), "singular result not cleared")

endmodule

`default_nettype wire

/* src/segment_triangle_intersect.sv */
// ----------------------------------------------------------------------------
// segment_triangle_intersect
// Fixed-point test of a motion segment against one configured triangle.
// ----------------------------------------------------------------------------
// Each transfer on the slave stream carries one segment: the current and the
// goal position, six signed coordinates. Each transfer on the master stream
// carries the answer for one segment in the same order: the hit flag, the
// segment parameter t, the intersection point, the behind-plane flag and the
// singular flag. The configuration channel writes the triangle vertices, the
// unit normal, the inflation radius and the mode; it is always ready, and the
// user must write it only while no segment is in flight, as the block itself
// does not enforce this. The pipeline takes one segment in every cycle while
// s_tready is high. A segment's result passes COORD_BITS + 14 register stages
// on its way to the master side: seven stages build the determinants,
// COORD_BITS + 5 stages normalise them and divide, one bit of t per stage,
// and two stages form the point and hold it in the output register.
// When the receiver stalls, the output register keeps its result and one
// more result drops into a skid stage; only once that stage is full does
// s_tready fall, and the whole pipeline then holds still, losing nothing.
// Synchronous reset empties the pipeline by clearing every valid bit and
// returns the configuration registers to zero; data registers are not reset.
// ----------------------------------------------------------------------------
`default_nettype none

module segment_triangle_intersect import sti_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                                     clk,
  input  logic                                     rst,
  // Configuration write channel.
  input  logic                                     cfg_valid,
  output logic                                     cfg_ready,
  input  logic [CFG_IDX_BITS-1:0]                  cfg_index,
  input  logic [3*COORD_BITS-1:0]                  cfg_data,
  // Segment input. tdata from bit 0: cur_x, cur_y, cur_z, goal_x, goal_y,
  // goal_z.
  input  logic                                     s_tvalid,
  output logic                                     s_tready,
  input  logic [((6*COORD_BITS+7)/8)*8-1:0]        s_tdata,
  // Result output. tdata from bit 0: hit, seg_param, point_x, point_y,
  // point_z, behind_plane, singular, then zero padding.
  output logic                                     m_tvalid,
  input  logic                                     m_tready,
  output logic [((4*COORD_BITS+3+7)/8)*8-1:0]      m_tdata
);

  localparam int C     = COORD_BITS;
  localparam int F     = FRAC_BITS;
  localparam int SW    = 6 * C;
  localparam int OUT_W = ((4 * C + 3 + 7) / 8) * 8;
  localparam int TW    = det_w(C, F);

  // Configuration registers.
  logic [3*C-1:0] vertex_a, vertex_b, vertex_c, unit_normal;
  logic [C-2:0]   inflate_radius;
  logic           use_translated;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_a       <= '0;
      vertex_b       <= '0;
      vertex_c       <= '0;
      unit_normal    <= '0;
      inflate_radius <= '0;
      use_translated <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_VERTEX_A:       vertex_a       <= cfg_data;
        REG_VERTEX_B:       vertex_b       <= cfg_data;
        REG_VERTEX_C:       vertex_c       <= cfg_data;
        REG_UNIT_NORMAL:    unit_normal    <= cfg_data;
        REG_INFLATE_RADIUS: inflate_radius <= cfg_data[C-2:0];
        REG_USE_TRANSLATED: use_translated <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // Per-axis views of the packed vertex and normal registers.
  logic signed [C-1:0] va [3], vb [3], vc [3], nrm [3];

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      va[j]  = signed'(vertex_a[j*C +: C]);
      vb[j]  = signed'(vertex_b[j*C +: C]);
      vc[j]  = signed'(vertex_c[j*C +: C]);
      nrm[j] = signed'(unit_normal[j*C +: C]);
    end
  end

  // The whole pipeline advances together; it holds only when the skid
  // stage at the output is occupied.
  logic en;

  assign s_tready = en;

  logic                 g_valid, g_behind;
  logic [SW-1:0]        g_side;
  logic signed [TW-1:0] g_dd, g_nt, g_nu, g_nv;

  sti_geom #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_geom (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .in_valid   (s_tvalid),
    .in_side    (s_tdata[SW-1:0]),
    .va         (va),
    .vb         (vb),
    .vc         (vc),
    .nrm        (nrm),
    .radius     (inflate_radius),
    .use_tr     (use_translated),
    .out_valid  (g_valid),
    .out_side   (g_side),
    .out_behind (g_behind),
    .dd         (g_dd),
    .nt         (g_nt),
    .nu         (g_nu),
    .nv         (g_nv)
  );

  logic                d_valid;
  logic [SW-1:0]       d_side;
  item_flags_t         d_flags;
  logic signed [C-1:0] d_tq;

  sti_div #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (g_valid),
    .in_side   (g_side),
    .in_behind (g_behind),
    .dd        (g_dd),
    .nt        (g_nt),
    .nu        (g_nu),
    .nv        (g_nv),
    .out_valid (d_valid),
    .out_side  (d_side),
    .out_flags (d_flags),
    .tq        (d_tq)
  );

  item_flags_t  o_flags;
  logic [C-1:0] o_tq, o_px, o_py, o_pz;

  sti_out #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_out (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (d_valid),
    .in_side   (d_side),
    .in_flags  (d_flags),
    .in_tq     (d_tq),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_flags (o_flags),
    .out_tq    (o_tq),
    .out_px    (o_px),
    .out_py    (o_py),
    .out_pz    (o_pz)
  );

  assign m_tdata = OUT_W'({o_flags.singular, o_flags.behind, o_pz, o_py, o_px, o_tq,
                           o_flags.hit});

endmodule

`default_nettype wire
